@@ rtl/bfmh_pkg.sv @@
package bfmh_pkg;

    localparam int MaxBits     = 8192;
    localparam int StoreBytes  = MaxBits / 8;
    localparam int AddrW       = $clog2(StoreBytes);
    localparam int BitW        = $clog2(MaxBits);
    localparam int SizeW       = 14;
    localparam int HashCount   = 8;
    localparam int HashIdxW    = 3;

    localparam logic [1:0] OpKey   = 2'd0;
    localparam logic [1:0] OpClear = 2'd1;
    localparam logic [1:0] OpFill  = 2'd2;

    localparam logic [1:0] RegNumHashes = 2'd0;
    localparam logic [1:0] RegUsedBits  = 2'd1;

    localparam logic [31:0] Seed0 = 32'd5381;
    localparam logic [31:0] Seed2 = 32'd2166136261;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                absorb;
        logic                seed;
        logic                mod_start;
        logic [HashIdxW-1:0] hash_sel;
        logic                mem_rd;
        logic                mem_wr_set;
        logic                sweep_wr;
        logic                sweep_value;
        logic                sweep_start;
        logic                count_inc;
        logic                count_clear;
        logic                count_fill;
        logic                miss_clear;
    } bfmh_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mod_done;
        logic sweep_last;
        logic count_full;
        logic bit_hit;
    } bfmh_sts_t;

endpackage

@@ rtl/bfmh_ram.sv @@
module bfmh_ram #(
    parameter int Width = 8,
    parameter int Depth = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/bfmh_mod.sv @@
module bfmh_mod
    import bfmh_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [31:0]      dividend,
    input  logic [SizeW-1:0] divisor,
    output logic             done,
    output logic [BitW-1:0]  remainder
);

    logic [31:0]        quot_reg, quot_next;
    logic [SizeW:0]     rem_reg, rem_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic [SizeW+1:0]   trial;

    // Restoring remainder, one dividend bit per cycle.
    always_comb begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg, quot_reg[31]};
        if (start) begin
            quot_next = dividend;
            rem_next  = '0;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {2'b00, divisor}) begin
                rem_next = (SizeW+1)'(trial - {2'b00, divisor});
            end else begin
                rem_next = trial[SizeW:0];
            end
            quot_next = {quot_reg[30:0], 1'b0};
            cnt_next  = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign done      = busy_reg && (cnt_reg == 6'd1);
    assign remainder = BitW'(rem_next);

endmodule

@@ rtl/bfmh_datapath.sv @@
module bfmh_datapath
    import bfmh_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  bfmh_cmd_t        cmd,
    input  logic [7:0]       key_byte,
    input  logic [SizeW-1:0] size,
    output bfmh_sts_t        sts,
    output logic [31:0]      element_count
);

    logic [31:0]     h_reg [HashCount];
    logic [31:0]     h_next [HashCount];
    logic [31:0]     elf_h;
    logic [31:0]     hsel;
    logic [31:0]     count_reg;
    logic [AddrW-1:0] sweep_reg, sweep_next;
    logic [AddrW-1:0] sweep_end;
    logic [BitW-1:0] bit_reg, rem;
    logic            mod_done;
    logic            we;
    logic [AddrW-1:0] waddr;
    logic [7:0]      wdata, rdata;
    logic [31:0]     b;

    assign b = {24'd0, key_byte};

    // Per-byte update of the eight running hashes.
    always_comb begin
        h_next[0] = h_reg[0] * 32'd33 + b;
        elf_h     = (h_reg[1] << 4) + b;
        if (elf_h[31:28] != 4'd0) begin
            elf_h = (elf_h ^ {24'd0, elf_h[31:28], 4'd0}) & 32'h0FFF_FFFF;
        end
        h_next[1] = elf_h;
        h_next[2] = (h_reg[2] ^ b) * 32'd16777619;
        h_next[3] = h_reg[3] * 32'd129 + b + 32'd987654321;
        h_next[4] = h_reg[4] * 32'd33 + b;
        h_next[5] = b + (h_reg[5] << 6) + (h_reg[5] << 16) - h_reg[5];
        h_next[6] = h_reg[6] + b;
        h_next[7] = h_reg[7] + b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.seed) begin
            for (int i = 0; i < HashCount; i++) begin
                h_reg[i] <= '0;
            end
            h_reg[0] <= Seed0;
            h_reg[2] <= Seed2;
        end else if (cmd.absorb) begin
            for (int i = 0; i < HashCount; i++) begin
                h_reg[i] <= h_next[i];
            end
        end
    end

    // Selected hash, djb masked to 31 bits.
    always_comb begin
        hsel = h_reg[cmd.hash_sel];
        if (cmd.hash_sel == '0) begin
            hsel[31] = 1'b0;
        end
    end

    bfmh_mod u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.mod_start),
        .dividend  (hsel),
        .divisor   (size),
        .done      (mod_done),
        .remainder (rem)
    );

    always_ff @(posedge aclk) begin
        if (mod_done) begin
            bit_reg <= rem;
        end
    end

    // Element count.
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.count_clear) begin
            count_reg <= '0;
        end else if (cmd.count_fill) begin
            count_reg <= '1;
        end else if (cmd.count_inc) begin
            count_reg <= count_reg + 32'd1;
        end
    end

    // Sweep address for clear and fill.
    assign sweep_end = AddrW'((({1'b0, size} + 15'd7) >> 3) - 15'd1);
    always_comb begin
        sweep_next = sweep_reg;
        if (cmd.sweep_start) begin
            sweep_next = '0;
        end else if (cmd.sweep_wr) begin
            sweep_next = sweep_reg + AddrW'(1);
        end
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_reg <= '0;
        end else begin
            sweep_reg <= sweep_next;
        end
    end

    // Store write: sweep byte or read-modify-write bit set.
    always_comb begin
        we    = cmd.sweep_wr || cmd.mem_wr_set;
        waddr = cmd.sweep_wr ? sweep_reg : bit_reg[BitW-1:3];
        wdata = cmd.sweep_wr ? {8{cmd.sweep_value}}
                             : (rdata | (8'd1 << bit_reg[2:0]));
    end

    bfmh_ram #(.Width(8), .Depth(StoreBytes)) u_store (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (bit_reg[BitW-1:3]),
        .rdata (rdata)
    );

    assign sts.mod_done   = mod_done;
    assign sts.sweep_last = (sweep_reg == sweep_end);
    assign sts.count_full = (count_reg == 32'hFFFF_FFFF);
    assign sts.bit_hit    = rdata[bit_reg[2:0]];
    assign element_count  = count_reg;

endmodule

@@ rtl/bfmh_ctrl.sv @@
module bfmh_ctrl
    import bfmh_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_op,
    input  logic       s_is_query,
    input  logic       s_last_byte,
    input  logic [3:0] num_hashes,
    input  bfmh_sts_t  sts,
    output bfmh_cmd_t  cmd,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_is_member,
    output logic       m_was_query
);

    typedef enum logic [2:0] {
        S_IDLE, S_SWEEP, S_MOD, S_READ, S_CHECK, S_NEXT, S_DONE
    } state_t;

    state_t              state_reg;
    logic                query_reg;
    logic                member_reg;
    logic [3:0]          k_reg;
    logic [HashIdxW:0]   idx_reg;
    logic                fill_reg;
    logic                out_free;
    logic                take;

    // The result register frees when taken.
    assign out_free = !m_valid || m_ready;
    assign s_ready  = (state_reg == S_IDLE) && out_free;
    assign take     = s_valid && s_ready;

    always_comb begin
        cmd             = '0;
        cmd.hash_sel    = idx_reg[HashIdxW-1:0];
        cmd.sweep_value = fill_reg;
        if (take && s_op == OpKey) begin
            cmd.absorb = 1'b1;
        end
        // An add counts as soon as its last byte is taken.
        if (take && s_op == OpKey && s_last_byte && !s_is_query) begin
            cmd.count_inc = 1'b1;
        end
        if (take && s_op == OpClear) begin
            cmd.sweep_start = 1'b1;
            cmd.count_clear = 1'b1;
        end
        if (take && s_op == OpFill) begin
            cmd.sweep_start = 1'b1;
            cmd.count_fill  = 1'b1;
        end
        case (state_reg)
            S_SWEEP: cmd.sweep_wr = 1'b1;
            S_NEXT:  cmd.mod_start = (idx_reg < k_reg);
            S_READ:  cmd.mem_rd = 1'b1;
            S_CHECK: cmd.mem_wr_set = !query_reg;
            S_DONE:  cmd.seed = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid     <= 1'b0;
            query_reg   <= 1'b0;
            member_reg  <= 1'b0;
            k_reg       <= '0;
            idx_reg     <= '0;
            fill_reg    <= 1'b0;
            m_is_member <= 1'b0;
            m_was_query <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                m_valid <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (take && (s_op == OpClear || s_op == OpFill)) begin
                        fill_reg  <= (s_op == OpFill);
                        state_reg <= S_SWEEP;
                    end else if (take && s_op == OpKey && s_last_byte) begin
                        query_reg  <= s_is_query;
                        member_reg <= 1'b1;
                        k_reg      <= (num_hashes > 4'd8) ? 4'd8 : num_hashes;
                        idx_reg    <= '0;
                        state_reg  <= S_NEXT;
                    end
                end
                S_SWEEP: begin
                    if (sts.sweep_last) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_NEXT: begin
                    if (cmd.mod_start && !(query_reg && (!member_reg || sts.count_full)))
                    begin
                        state_reg <= S_MOD;
                    end else begin
                        state_reg <= S_DONE;
                    end
                end
                S_MOD: begin
                    if (sts.mod_done) begin
                        state_reg <= S_READ;
                    end
                end
                S_READ: state_reg <= S_CHECK;
                S_CHECK: begin
                    if (query_reg && !sts.bit_hit) begin
                        member_reg <= 1'b0;
                    end
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= S_NEXT;
                end
                S_DONE: begin
                    m_valid     <= 1'b1;
                    m_is_member <= query_reg && member_reg;
                    m_was_query <= query_reg;
                    state_reg   <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

@@ rtl/bloom_filter_multi_hash.sv @@
// Channel  | Ports                                     | Direction
// input    | s_valid s_ready s_op s_is_query s_key_byte s_last_byte | in
// result   | m_valid m_ready m_is_member m_was_query m_element_count | out
// config   | psel penable pwrite paddr pwdata prdata pready        | APB
// A key byte that is not last is absorbed when taken. A key end yields its
// result word after the bit-serial remainder unit, shared by the k hashes,
// has run once per hash with a store read and, for an add, a store write;
// a query stops early at its first clear bit. Clear and fill write one store
// byte per cycle, (size+7)/8 bytes. After reset a clearing pass zeroes all
// 1024 store bytes with s_ready low; a stalled result holds off all input.
module bloom_filter_multi_hash
    import bfmh_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic        s_is_query,
    input  logic [7:0]  s_key_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_is_member,
    output logic        m_was_query,
    output logic [31:0] m_element_count,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [3:0]       num_hashes_reg;
    logic [SizeW-1:0] used_bits_reg;
    logic [SizeW-1:0] size;
    logic [1:0]       reg_idx;
    bfmh_cmd_t        cmd;
    bfmh_sts_t        sts;
    logic             clr_busy_reg;
    logic [AddrW:0]   clr_cnt_reg;

    assign pready  = 1'b1;
    assign reg_idx = {1'b0, paddr[2]};

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_hashes_reg <= 4'd4;
            used_bits_reg  <= SizeW'(MaxBits);
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                RegNumHashes: num_hashes_reg <= pwdata[3:0];
                RegUsedBits:  used_bits_reg  <= pwdata[SizeW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            RegNumHashes: prdata = {28'd0, num_hashes_reg};
            RegUsedBits:  prdata = {{(32-SizeW){1'b0}}, used_bits_reg};
            default:      prdata = '0;
        endcase
    end

    // Effective filter size, clamped to the legal range.
    always_comb begin
        if (used_bits_reg < SizeW'(8)) begin
            size = SizeW'(8);
        end else if (used_bits_reg > SizeW'(MaxBits)) begin
            size = SizeW'(MaxBits);
        end else begin
            size = used_bits_reg;
        end
    end

    // Clearing pass after reset, one store byte per cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else if (clr_busy_reg) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == (AddrW+1)'(StoreBytes - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    logic       ctl_ready;
    bfmh_cmd_t  ctl_cmd;
    logic [SizeW-1:0] dp_size;

    bfmh_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid && !clr_busy_reg),
        .s_ready     (ctl_ready),
        .s_op        (s_op),
        .s_is_query  (s_is_query),
        .s_last_byte (s_last_byte),
        .num_hashes  (num_hashes_reg),
        .sts         (sts),
        .cmd         (ctl_cmd),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_is_member (m_is_member),
        .m_was_query (m_was_query)
    );

    assign s_ready = ctl_ready && !clr_busy_reg;

    // During the clearing pass the sweep writes zeros over the whole store.
    always_comb begin
        cmd     = ctl_cmd;
        dp_size = size;
        if (clr_busy_reg) begin
            cmd.sweep_wr    = 1'b1;
            cmd.sweep_value = 1'b0;
            dp_size         = SizeW'(MaxBits);
        end
    end

    bfmh_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .key_byte      (s_key_byte),
        .size          (dp_size),
        .sts           (sts),
        .element_count (m_element_count)
    );

endmodule
